// ----- rtl/hwt_pkg.sv -----
// Shared types, constants and an arithmetic helper for the 2D Haar wavelet core.
package hwt_pkg;

	localparam int COEF_W     = 20;
	localparam int SUM_W      = COEF_W + 2;
	localparam int PIX_W      = 8;
	localparam int ADDR_IN_W  = 6;
	localparam int GEOM_W     = 7;
	localparam int LVL_W      = 3;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_FRAC_BITS  = 4;
	localparam int DEF_MAX_LEVELS = 6;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [GEOM_W-1:0] active_width;
		logic [GEOM_W-1:0] active_height;
		logic [LVL_W-1:0]  levels;
	} cfg_t;

	typedef struct packed {
		logic       take;       // input transfer this cycle
		logic       run_init;   // latch geometry and level count
		logic       lvl_next;   // halve region, count down level
		logic       blk_rd;     // issue source read for tap ph
		logic       tap_shift;  // shift source read data into taps
		logic       blk_wr;     // write result quadrant ph
		logic       blk_next;   // advance block counters
		logic       cp_rd;      // read result entry for copy-back
		logic       run_done;   // push run result into output path
		logic [1:0] ph;
	} cmd_t;

	typedef struct packed {
		logic s1_free;
		logic lv_zero;
		logic region_empty;
		logic blk_last;
		logic cp_last;
	} status_t;

	// Arithmetic shift right by one (floor), then saturate to COEF_W bits.
	function automatic logic signed [COEF_W-1:0] half_sat(input logic signed [SUM_W-1:0] s);
		logic signed [COEF_W:0] h;
		h = s[SUM_W-1:1];
		if (h[COEF_W] != h[COEF_W-1]) begin
			return h[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end
		return h[COEF_W-1:0];
	endfunction

endpackage

// ----- rtl/hwt_ctrl.sv -----
// Sequencer for item intake and the multi-level transform walk.
module hwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  hwt_pkg::opcode_t  op,
	input  hwt_pkg::status_t  status,
	output logic              in_stall,
	output hwt_pkg::cmd_t     cmd
);
	import hwt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LVL_CHK,
		ST_BLK_RD,
		ST_BLK_D,
		ST_BLK_WR,
		ST_CP,
		ST_CP_DRAIN,
		ST_LVL_NEXT,
		ST_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] ph_q;
	logic       take;

	assign in_stall = !((state_q == ST_IDLE) && status.s1_free);
	assign take     = in_valid && !in_stall;

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.ph        = ph_q;
		cmd.run_init  = take && (op == OP_RUN);
		cmd.lvl_next  = (state_q == ST_LVL_NEXT);
		cmd.blk_rd    = (state_q == ST_BLK_RD);
		cmd.tap_shift = ((state_q == ST_BLK_RD) && (ph_q != 2'd0)) || (state_q == ST_BLK_D);
		cmd.blk_wr    = (state_q == ST_BLK_WR);
		cmd.blk_next  = (state_q == ST_BLK_WR) && (ph_q == 2'd3);
		cmd.cp_rd     = (state_q == ST_CP);
		cmd.run_done  = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ph_q <= 2'd0;
					if (take && (op == OP_RUN)) begin
						state_q <= ST_LVL_CHK;
					end
				end
				ST_LVL_CHK: begin
					ph_q <= 2'd0;
					priority if (status.lv_zero) begin
						state_q <= ST_FINISH;
					end else if (status.region_empty) begin
						state_q <= ST_LVL_NEXT;
					end else begin
						state_q <= ST_BLK_RD;
					end
				end
				ST_BLK_RD: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= ST_BLK_D;
					end
				end
				ST_BLK_D: begin
					ph_q    <= 2'd0;
					state_q <= ST_BLK_WR;
				end
				ST_BLK_WR: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= status.blk_last ? ST_CP : ST_BLK_RD;
					end
				end
				ST_CP: begin
					if (status.cp_last) begin
						state_q <= ST_CP_DRAIN;
					end
				end
				ST_CP_DRAIN: begin
					state_q <= ST_LVL_NEXT;
				end
				ST_LVL_NEXT: begin
					state_q <= ST_LVL_CHK;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/hwt_datapath.sv -----
// Frame stores, block taps, butterfly arithmetic and output register.
module hwt_datapath #(
	parameter int MAX_WIDTH  = hwt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hwt_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hwt_pkg::DEF_FRAC_BITS,
	parameter int MAX_LEVELS = hwt_pkg::DEF_MAX_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hwt_pkg::cfg_t                       cfg,
	input  hwt_pkg::cmd_t                       cmd,
	input  hwt_pkg::opcode_t                    op,
	input  logic [hwt_pkg::ADDR_IN_W-1:0]       row,
	input  logic [hwt_pkg::ADDR_IN_W-1:0]       col,
	input  logic [hwt_pkg::PIX_W-1:0]           pixel,
	input  logic                                out_stall,
	output hwt_pkg::status_t                    status,
	output logic                                out_valid,
	output logic signed [hwt_pkg::COEF_W-1:0]   coefficient,
	output logic                                read_valid
);
	import hwt_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] frame_addr(input logic [GEOM_W-1:0] r,
	                                             input logic [GEOM_W-1:0] c);
		logic [31:0] t;
		t = 32'(r) * MAX_WIDTH + 32'(c);
		return t[AW-1:0];
	endfunction

	logic signed [COEF_W-1:0] src_mem [DEPTH];
	logic signed [COEF_W-1:0] res_mem [DEPTH];
	logic signed [COEF_W-1:0] src_rd_q, res_rd_q;

	logic [GEOM_W-1:0] w_eff, h_eff;
	logic [LVL_W-1:0]  n_eff;
	logic [GEOM_W-1:0] hw_q, hh_q, bx_q, by_q, cpr_q, cpc_q;
	logic [LVL_W-1:0]  lv_q;

	logic signed [COEF_W-1:0] a_q, b_q, c_q, d_q;

	logic          cp_wr_s1;
	logic [AW-1:0] cp_waddr_s1;

	logic s1_v_q, s1_rd_q;
	logic out_v_q, out_rv_q;
	logic signed [COEF_W-1:0] out_coef_q;
	logic out_ready;

	logic          in_frame;
	logic [AW-1:0] item_addr;
	logic signed [COEF_W-1:0] pix_val;

	logic          src_we, src_re, res_we, res_re;
	logic [AW-1:0] src_waddr, src_raddr, res_waddr, res_raddr;
	logic signed [COEF_W-1:0] src_wdata, res_wdata;

	logic signed [SUM_W-1:0] ea, eb, ec, ed, sum;
	logic [GEOM_W-1:0]       wr_r, wr_c, rd_r, rd_c;
	logic [GEOM_W-1:0]       cp_col_last, cp_row_last;

	// Clamp geometry to what the stores hold and the level count to MAX_LEVELS.
	assign w_eff = (32'(cfg.active_width) > MAX_WIDTH) ? GEOM_W'(MAX_WIDTH) : cfg.active_width;
	assign h_eff = (32'(cfg.active_height) > MAX_HEIGHT) ? GEOM_W'(MAX_HEIGHT)
	                                                      : cfg.active_height;
	assign n_eff = (32'(cfg.levels) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : cfg.levels;

	assign in_frame  = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
	assign item_addr = frame_addr({1'b0, row}, {1'b0, col});
	assign pix_val   = COEF_W'(pixel) << FRAC_BITS;

	assign cp_col_last = (hw_q << 1) - GEOM_W'(1);
	assign cp_row_last = (hh_q << 1) - GEOM_W'(1);

	assign out_ready = !out_v_q || !out_stall;

	assign status.s1_free      = !s1_v_q || out_ready;
	assign status.lv_zero      = (lv_q == '0);
	assign status.region_empty = (hw_q == '0) || (hh_q == '0);
	assign status.blk_last     = (bx_q == hw_q - GEOM_W'(1)) && (by_q == hh_q - GEOM_W'(1));
	assign status.cp_last      = (cpc_q == cp_col_last) && (cpr_q == cp_row_last);

	// Source read address for tap ph of the current 2x2 block.
	always_comb begin
		unique case (cmd.ph)
			2'd0: begin rd_r = {by_q[GEOM_W-2:0], 1'b0}; rd_c = {bx_q[GEOM_W-2:0], 1'b0}; end
			2'd1: begin rd_r = {by_q[GEOM_W-2:0], 1'b0}; rd_c = {bx_q[GEOM_W-2:0], 1'b1}; end
			2'd2: begin rd_r = {by_q[GEOM_W-2:0], 1'b1}; rd_c = {bx_q[GEOM_W-2:0], 1'b0}; end
			2'd3: begin rd_r = {by_q[GEOM_W-2:0], 1'b1}; rd_c = {bx_q[GEOM_W-2:0], 1'b1}; end
			default: begin rd_r = '0; rd_c = '0; end
		endcase
	end

	// Butterfly for quadrant ph: average, horizontal, vertical, diagonal.
	always_comb begin
		ea = SUM_W'(a_q);
		eb = SUM_W'(b_q);
		ec = SUM_W'(c_q);
		ed = SUM_W'(d_q);
		unique case (cmd.ph)
			2'd0: begin sum = ea + eb + ec + ed; wr_r = by_q;        wr_c = bx_q;        end
			2'd1: begin sum = ea - eb + ec - ed; wr_r = by_q;        wr_c = bx_q + hw_q; end
			2'd2: begin sum = ea + eb - ec - ed; wr_r = by_q + hh_q; wr_c = bx_q;        end
			2'd3: begin sum = ea - eb - ec + ed; wr_r = by_q + hh_q; wr_c = bx_q + hw_q; end
			default: begin sum = '0; wr_r = '0; wr_c = '0; end
		endcase
	end

	always_comb begin
		src_we    = cp_wr_s1 || (cmd.take && (op == OP_LOAD) && in_frame);
		src_waddr = cp_wr_s1 ? cp_waddr_s1 : item_addr;
		src_wdata = cp_wr_s1 ? res_rd_q : pix_val;
		src_re    = cmd.blk_rd;
		src_raddr = frame_addr(rd_r, rd_c);

		res_we    = cmd.blk_wr || (cmd.take && (op == OP_LOAD) && in_frame);
		res_waddr = cmd.blk_wr ? frame_addr(wr_r, wr_c) : item_addr;
		res_wdata = cmd.blk_wr ? half_sat(sum) : pix_val;
		res_re    = cmd.cp_rd || (cmd.take && (op == OP_READ) && in_frame);
		res_raddr = cmd.cp_rd ? frame_addr(cpr_q, cpc_q) : item_addr;
	end

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[src_waddr] <= src_wdata;
		end
		if (src_re) begin
			src_rd_q <= src_mem[src_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		if (res_re) begin
			res_rd_q <= res_mem[res_raddr];
		end
	end

	// Level geometry, block and copy counters, taps, read flag and output data.
	always_ff @(posedge clk) begin
		if (cmd.run_init || cmd.lvl_next) begin
			bx_q  <= '0;
			by_q  <= '0;
			cpr_q <= '0;
			cpc_q <= '0;
		end
		if (cmd.run_init) begin
			hw_q <= w_eff >> 1;
			hh_q <= h_eff >> 1;
			lv_q <= n_eff;
		end else if (cmd.lvl_next) begin
			hw_q <= hw_q >> 1;
			hh_q <= hh_q >> 1;
			lv_q <= lv_q - LVL_W'(1);
		end
		if (cmd.blk_next) begin
			if (bx_q == hw_q - GEOM_W'(1)) begin
				bx_q <= '0;
				by_q <= by_q + GEOM_W'(1);
			end else begin
				bx_q <= bx_q + GEOM_W'(1);
			end
		end
		if (cmd.cp_rd) begin
			cp_waddr_s1 <= frame_addr(cpr_q, cpc_q);
			if (cpc_q == cp_col_last) begin
				cpc_q <= '0;
				cpr_q <= cpr_q + GEOM_W'(1);
			end else begin
				cpc_q <= cpc_q + GEOM_W'(1);
			end
		end
		if (cmd.tap_shift) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= src_rd_q;
		end
		if (cmd.take) begin
			s1_rd_q <= (op == OP_READ) && in_frame;
		end else if (cmd.run_done) begin
			s1_rd_q <= 1'b0;
		end
		if (s1_v_q && out_ready) begin
			out_coef_q <= s1_rd_q ? res_rd_q : '0;
			out_rv_q   <= s1_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_wr_s1 <= 1'b0;
			s1_v_q   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			cp_wr_s1 <= cmd.cp_rd;
			priority if ((cmd.take && (op != OP_RUN)) || cmd.run_done) begin
				s1_v_q <= 1'b1;
			end else if (out_ready) begin
				s1_v_q <= 1'b0;
			end
			if (out_ready) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign coefficient = out_coef_q;
	assign read_valid  = out_rv_q;

endmodule

// ----- rtl/haar_wavelet_2d_multilevel_core.sv -----
// Top level of the multi-level 2D Haar wavelet core: configuration and glue.
//
// Items arrive on the input channel with an opcode. Load, read and no-op items
// flow at one transfer per cycle while no run is in progress and the result
// channel does not stall; each gives one result, a read returning its
// coefficient through the frame read register and then the output register.
// A run item holds off further input while it walks the frame and gives one
// zero result when done. Per level the run reads the four source taps of each
// of the hw x hh blocks through the single source read port and writes the
// four quadrants through the single result write port, then copies the level's
// region back to the source frame and does level bookkeeping. Frame stores
// are not cleared after reset: read only entries that were loaded. Write
// configuration only while the block is idle.
module haar_wavelet_2d_multilevel_core #(
	parameter int MAX_WIDTH  = hwt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hwt_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hwt_pkg::DEF_FRAC_BITS,
	parameter int MAX_LEVELS = hwt_pkg::DEF_MAX_LEVELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wen,
	input  logic [hwt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hwt_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hwt_pkg::OP_W-1:0]           opcode,
	input  logic [hwt_pkg::ADDR_IN_W-1:0]      row,
	input  logic [hwt_pkg::ADDR_IN_W-1:0]      col,
	input  logic [hwt_pkg::PIX_W-1:0]          pixel,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [hwt_pkg::COEF_W-1:0]  coefficient,
	output logic                               read_valid
);
	import hwt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS        = 2'd2;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;
	opcode_t op;

	assign op = opcode_t'(opcode);

	// Configuration registers; writes to an unlisted index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_width  <= GEOM_W'(64);
			cfg_q.active_height <= GEOM_W'(64);
			cfg_q.levels        <= LVL_W'(1);
		end else if (cfg_wen) begin
			if (cfg_index == REG_ACTIVE_WIDTH) begin
				cfg_q.active_width <= cfg_data[GEOM_W-1:0];
			end
			if (cfg_index == REG_ACTIVE_HEIGHT) begin
				cfg_q.active_height <= cfg_data[GEOM_W-1:0];
			end
			if (cfg_index == REG_LEVELS) begin
				cfg_q.levels <= cfg_data[LVL_W-1:0];
			end
		end
	end

	// Sequencer: intake handshake and level/block/copy walk.
	hwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Frame stores, butterfly and result path.
	hwt_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.op          (op),
		.row         (row),
		.col         (col),
		.pixel       (pixel),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.coefficient (coefficient),
		.read_valid  (read_valid)
	);

endmodule
